// ===== hw/rtl/ffita_pkg.sv =====
// Shared types and constants for the first-fit interval track assigner.
package ffita_pkg;

  localparam int NUM_TRACKS = 5;
  localparam int PREF_SLOTS = 5;
  localparam int IDX_W      = 3;
  localparam int FIT_SPAN   = 1 << IDX_W;
  localparam int TIME_W     = 16;
  localparam int COUNT_W    = 3;

  typedef logic [TIME_W-1:0] time_t;
  typedef logic [IDX_W-1:0]  idx_t;

  typedef enum logic {
    CMD_PLACE = 1'b0,
    CMD_CLEAR = 1'b1
  } cmd_t;

  typedef struct packed {
    logic               command;
    time_t              start_time;
    time_t              finish_time;
    logic [COUNT_W-1:0] pref_count;
    idx_t               pref_first;
    idx_t               pref_second;
    idx_t               pref_third;
    idx_t               pref_fourth;
    idx_t               pref_fifth;
  } req_item_t;

  typedef struct packed {
    logic placed;
    idx_t track_index;
  } rsp_item_t;

  typedef struct packed {
    logic  found;
    idx_t  idx;
  } sel_t;

  typedef struct packed {
    logic  clr;
    logic  we;
    idx_t  idx;
    time_t finish;
  } track_upd_t;

endpackage

// ===== hw/rtl/ffita_if.sv =====
// Valid/ready channel interfaces for request and response beats.
interface ffita_req_if
  import ffita_pkg::*;
();
  logic      valid;
  logic      ready;
  req_item_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

interface ffita_rsp_if
  import ffita_pkg::*;
();
  logic      valid;
  logic      ready;
  rsp_item_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

// ===== hw/rtl/ffita_tracks.sv =====
// Per-track occupancy and last-finish registers.
module ffita_tracks
  import ffita_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  input  track_upd_t            upd,
  output logic [NUM_TRACKS-1:0] used,
  output time_t                 last [NUM_TRACKS]
);

  always_ff @(posedge clk) begin
    if (rst || upd.clr) begin
      used <= '0;
    end else if (upd.we) begin
      for (int t = 0; t < NUM_TRACKS; t++) begin
        if (upd.idx == IDX_W'(t)) begin
          used[t] <= 1'b1;
        end
      end
    end
  end

  // last finish is don't-care while a track is unused
  always_ff @(posedge clk) begin
    if (upd.we) begin
      for (int t = 0; t < NUM_TRACKS; t++) begin
        if (upd.idx == IDX_W'(t)) begin
          last[t] <= upd.finish;
        end
      end
    end
  end

endmodule

// ===== hw/rtl/ffita_select.sv =====
// Fit test per track and preference-then-first-fit priority pick.
module ffita_select
  import ffita_pkg::*;
(
  input  req_item_t             item,
  input  logic [NUM_TRACKS-1:0] used,
  input  time_t                 last [NUM_TRACKS],
  output sel_t                  sel
);

  logic [FIT_SPAN-1:0] fits;
  idx_t                pref [PREF_SLOTS];
  logic                pref_hit;
  idx_t                pref_idx;
  logic                ff_hit;
  idx_t                ff_idx;

  assign pref[0] = item.pref_first;
  assign pref[1] = item.pref_second;
  assign pref[2] = item.pref_third;
  assign pref[3] = item.pref_fourth;
  assign pref[4] = item.pref_fifth;

  // entries at or above NUM_TRACKS stay zero, so bad preferences never fit
  always_comb begin
    fits = '0;
    for (int t = 0; t < NUM_TRACKS; t++) begin
      fits[t] = !used[t] || (last[t] < item.start_time);
    end
  end

  // count above the slot number simply enables every slot
  always_comb begin
    pref_hit = 1'b0;
    pref_idx = '0;
    for (int k = PREF_SLOTS - 1; k >= 0; k--) begin
      if ((COUNT_W'(k) < item.pref_count) && fits[pref[k]]) begin
        pref_hit = 1'b1;
        pref_idx = pref[k];
      end
    end
  end

  always_comb begin
    ff_hit = 1'b0;
    ff_idx = '0;
    for (int t = NUM_TRACKS - 1; t >= 0; t--) begin
      if (fits[t]) begin
        ff_hit = 1'b1;
        ff_idx = IDX_W'(t);
      end
    end
  end

  always_comb begin
    sel.found = pref_hit || ff_hit;
    sel.idx   = pref_hit ? pref_idx : ff_idx;
  end

endmodule

// ===== hw/rtl/first_fit_interval_track_assigner.sv =====
// Top level of the first-fit interval track assigner.
//
// Takes one request beat per cycle on req and returns one response beat on
// rsp for every place command; a clear command empties all tracks and gives
// no response. A request is captured in an input register, and from there
// the fit test of all tracks, the preference-then-first-fit pick and the
// track update all happen together, so the following request already sees
// the updated tracks; the result of a place command goes to the response
// register. The rate of one request per cycle holds while rsp does not
// stall. The single response register decouples the sides; when rsp
// stalls, the pending request waits in the input register and req.ready
// drops only once that register is also full. A track fits when it is empty
// or its last finish is strictly below the new start; preferred tracks are
// tried in list order, then all tracks from index 0. A spilled interval
// reports placed = 0 and track_index = 0 and leaves the tracks unchanged.
module first_fit_interval_track_assigner
  import ffita_pkg::*;
(
  input logic         clk,
  input logic         rst,
  ffita_req_if.sink   req,
  ffita_rsp_if.source rsp
);

  // input register
  logic      s1_valid;
  req_item_t s1_item;

  logic                  is_clear;
  logic                  fire;
  sel_t                  sel;
  track_upd_t            upd;
  logic [NUM_TRACKS-1:0] used;
  time_t                 last [NUM_TRACKS];

  assign is_clear = (s1_item.command == CMD_CLEAR);

  // clear beats produce nothing, so they never wait on rsp
  assign fire      = s1_valid && (is_clear || !rsp.valid || rsp.ready);
  assign req.ready = !s1_valid || fire;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (req.ready) begin
      s1_valid <= req.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (req.valid && req.ready) begin
      s1_item <= req.data;
    end
  end

  ffita_select u_select (
    .item (s1_item),
    .used (used),
    .last (last),
    .sel  (sel)
  );

  always_comb begin
    upd.clr    = fire && is_clear;
    upd.we     = fire && !is_clear && sel.found;
    upd.idx    = sel.idx;
    upd.finish = s1_item.finish_time;
  end

  ffita_tracks u_tracks (
    .clk  (clk),
    .rst  (rst),
    .upd  (upd),
    .used (used),
    .last (last)
  );

  // response register
  always_ff @(posedge clk) begin
    if (rst) begin
      rsp.valid <= 1'b0;
    end else if (fire && !is_clear) begin
      rsp.valid <= 1'b1;
    end else if (rsp.ready) begin
      rsp.valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (fire && !is_clear) begin
      rsp.data.placed      <= sel.found;
      rsp.data.track_index <= sel.found ? sel.idx : '0;
    end
  end

`ifndef SYNTHESIS
  a_idx_range: assert property (@(posedge clk) disable iff (rst)
    rsp.valid && rsp.data.placed |-> rsp.data.track_index < IDX_W'(NUM_TRACKS))
    else $error("placed beat names a track out of range");

  a_spill_zero: assert property (@(posedge clk) disable iff (rst)
    rsp.valid && !rsp.data.placed |-> rsp.data.track_index == '0)
    else $error("spilled beat carries a nonzero track index");

  a_clear_empties: assert property (@(posedge clk) disable iff (rst)
    fire && is_clear |=> used == '0)
    else $error("tracks not empty after clear");

  a_place_responds: assert property (@(posedge clk) disable iff (rst)
    fire && !is_clear |=> rsp.valid)
    else $error("place beat produced no response");

  a_place_marks: assert property (@(posedge clk) disable iff (rst)
    upd.we |=> used != '0)
    else $error("placement left all tracks empty");
`endif

endmodule
